// ===== rtl/ghtq_pkg.sv =====
// Shared types and constants for the ground height triangle query block.
// Used by every module under rtl; depends on nothing else.
package ghtq_pkg;

  localparam int CW      = 24;          // coordinate width
  localparam int DW      = CW + 1;      // vertex difference width
  localparam int REACH_W = 23;          // reach register width
  localparam int YW      = CW + 1;      // window and interpolated height width
  localparam int NW      = 2 * DW + 1;  // normal, determinant and weight width
  localparam int MAG_W   = NW - 1;      // magnitude of a normal or weight
  localparam int SPLIT   = 25;          // low piece width for wide products
  localparam int HI_W    = MAG_W - SPLIT;
  localparam int TRI_W   = HI_W + 2;    // width of three times a piece
  localparam int MW      = 28;          // multiplier operand width
  localparam int PW      = 2 * MW;      // multiplier product width
  localparam int AW      = 106;         // accumulator width
  localparam int SW      = 74;          // weighted height sum width
  localparam int WGW     = NW + 2;      // normalised weight width
  localparam int QW      = CW;          // quotient width
  localparam int RMW     = 76;          // divider remainder width
  localparam int SHIFT_W = 6;
  localparam int STEP_W  = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd26;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd23;

  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_BIT = 2;
  localparam logic REG_UP_REACH   = 1'b0;
  localparam logic REG_DOWN_REACH = 1'b1;

  localparam logic MODE_START    = 1'b0;
  localparam logic MODE_TRIANGLE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [23:0] vertex_a_x;
    logic signed [23:0] vertex_a_y;
    logic signed [23:0] vertex_a_z;
    logic signed [23:0] vertex_b_x;
    logic signed [23:0] vertex_b_y;
    logic signed [23:0] vertex_b_z;
    logic signed [23:0] vertex_c_x;
    logic signed [23:0] vertex_c_y;
    logic signed [23:0] vertex_c_z;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic               ground_found;
    logic signed [23:0] ground_height;
  } out_item_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic                 is_tri;
    logic                 last;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic signed [DW-1:0] e0x;
    logic signed [DW-1:0] e0y;
    logic signed [DW-1:0] e0z;
    logic signed [DW-1:0] e1x;
    logic signed [DW-1:0] e1y;
    logic signed [DW-1:0] e1z;
    logic signed [DW-1:0] bzc;
    logic signed [DW-1:0] cxb;
    logic signed [DW-1:0] azc;
    logic signed [DW-1:0] axc;
  } entry_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_NX, DST_NY, DST_NZ, DST_D, DST_W0, DST_W1, DST_SLOPE, DST_SUM
  } dest_t;

  typedef struct packed {
    logic               first;
    logic               last;
    logic               sub;
    logic [SHIFT_W-1:0] shift;
    dest_t              dest;
  } step_ctl_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_DRAIN, B_DIVSET, B_DIV, B_FINISH, B_EMIT
  } back_state_t;

endpackage

// ===== rtl/ground_height_triangle_query.sv =====
// Ground height query. A result follows every item marked last. A triangle holds the
// back part through take, 27 products through one shared multiplier, drain, divider
// set-up, 24 divider steps and compare; a start item is taken in the idle state, and an
// item marked last then passes the emit state, which waits for a free output register,
// to load the result register. The front stage and queue take further items meanwhile.
// Reset (synchronous, active high) clears the query state, the reach registers and all
// handshakes; there is no clearing pass.
module ground_height_triangle_query #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  ghtq_pkg::in_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output ghtq_pkg::out_item_t                 result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ghtq_pkg::ADDR_W-1:0]         paddr,
  input  logic [ghtq_pkg::DATA_W-1:0]         pwdata,
  output logic [ghtq_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import ghtq_pkg::*;

  logic [REACH_W-1:0] up_reach;
  logic [REACH_W-1:0] down_reach;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  entry_t             push_entry, pop_entry;

  // The configuration port never waits. Register index is the word address.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_reach   <= '0;
      down_reach <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[REG_IDX_BIT])
        REG_UP_REACH:   up_reach   <= pwdata[REACH_W-1:0];
        REG_DOWN_REACH: down_reach <= pwdata[REACH_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_BIT])
      REG_UP_REACH:   prdata = DATA_W'(up_reach);
      REG_DOWN_REACH: prdata = DATA_W'(down_reach);
      default:        prdata = '0;
    endcase
  end

  // The front stage classifies each item and forms the vertex differences, so the
  // back part starts its multiply sequence straight from the queue head.
  ghtq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ghtq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // The back part applies start items, runs the ground, containment and height
  // arithmetic for triangles, and holds the result in an output register so that
  // it can take the next item while the result waits.
  ghtq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .up_reach     (up_reach),
    .down_reach   (down_reach),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/ghtq_front.sv =====
// Front part: takes input items, classifies them and forms vertex differences.
// Depends on ghtq_pkg.
module ghtq_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ghtq_pkg::in_item_t item,
  output logic               push_valid,
  input  logic               push_ready,
  output ghtq_pkg::entry_t   push_entry
);
  import ghtq_pkg::*;

  logic   full;
  entry_t ent;
  entry_t ent_next;

  function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] p,
                                                input logic signed [CW-1:0] q);
    return DW'(p) - DW'(q);
  endfunction

  always_comb begin
    ent_next.is_tri = (item.mode == MODE_TRIANGLE);
    ent_next.last   = item.last_item;
    ent_next.ax     = item.vertex_a_x;
    ent_next.ay     = item.vertex_a_y;
    ent_next.az     = item.vertex_a_z;
    ent_next.by     = item.vertex_b_y;
    ent_next.cx     = item.vertex_c_x;
    ent_next.cy     = item.vertex_c_y;
    ent_next.cz     = item.vertex_c_z;
    ent_next.e0x    = diff(item.vertex_b_x, item.vertex_a_x);
    ent_next.e0y    = diff(item.vertex_b_y, item.vertex_a_y);
    ent_next.e0z    = diff(item.vertex_b_z, item.vertex_a_z);
    ent_next.e1x    = diff(item.vertex_c_x, item.vertex_a_x);
    ent_next.e1y    = diff(item.vertex_c_y, item.vertex_a_y);
    ent_next.e1z    = diff(item.vertex_c_z, item.vertex_a_z);
    ent_next.bzc    = diff(item.vertex_b_z, item.vertex_c_z);
    ent_next.cxb    = diff(item.vertex_c_x, item.vertex_b_x);
    ent_next.azc    = diff(item.vertex_a_z, item.vertex_c_z);
    ent_next.axc    = diff(item.vertex_a_x, item.vertex_c_x);
  end

  assign item_ready = !full || push_ready;
  assign push_valid = full;
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_valid && item_ready) begin
      full <= 1'b1;
    end else if (push_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      ent <= ent_next;
    end
  end

endmodule

// ===== rtl/ghtq_fifo.sv =====
// Short queue of classified items between the front and back parts.
// Depends on ghtq_pkg.
module ghtq_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ghtq_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ghtq_pkg::entry_t pop_entry
);
  import ghtq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/ghtq_back.sv =====
// Back part: shared multiply-accumulate sequencer, restoring divider, window test
// and running maximum. Depends on ghtq_pkg.
module ghtq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ghtq_pkg::REACH_W-1:0]  up_reach,
  input  logic [ghtq_pkg::REACH_W-1:0]  down_reach,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  ghtq_pkg::entry_t              pop_entry,
  output logic                          result_valid,
  input  logic                          result_ready,
  output ghtq_pkg::out_item_t           result
);
  import ghtq_pkg::*;

  back_state_t state, state_next;

  entry_t               ent;
  logic [STEP_W-1:0]    step;
  logic signed [CW-1:0] point_x, point_z, best_height;
  logic signed [YW-1:0] window_low, window_high;
  logic                 have_ground;
  logic signed [NW-1:0] nx, ny, nz, d_r, w0_r, w1_r;
  logic                 wall;
  logic signed [SW-1:0] sum_r;
  logic signed [PW-1:0] prod;
  step_ctl_t            pctl;
  logic                 pv;
  logic signed [AW-1:0] acc, acc_next, shifted, base;
  logic [RMW-1:0]       rem, dsh;
  logic [QW-1:0]        quo;
  logic [STEP_W-1:0]    dcnt;
  logic                 neg_r;

  logic signed [DW-1:0]  dx, dz;
  logic [MAG_W-1:0]      nxm, nym, nzm;
  logic [TRI_W-1:0]      ny3hi, ny3lo;
  logic signed [WGW-1:0] w2, dn, wn0, wn1, wn2;
  logic                  dneg, ok_w, d_zero, pass;
  logic signed [MW-1:0]  op_a, op_b;
  step_ctl_t             ctl;
  logic [SW-1:0]         msum;
  logic signed [YW-1:0]  y;
  logic                  slot_free;

  function automatic logic [MAG_W-1:0] mag_n(input logic signed [NW-1:0] v);
    return v[NW-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic [TRI_W-1:0] times3(input logic [HI_W-1:0] v);
    return {1'b0, v, 1'b0} + TRI_W'(v);
  endfunction

  // Operand views derived from held state.
  always_comb begin
    dx     = DW'(point_x) - DW'(ent.cx);
    dz     = DW'(point_z) - DW'(ent.cz);
    nxm    = mag_n(nx);
    nym    = mag_n(ny);
    nzm    = mag_n(nz);
    ny3hi  = times3(nym[MAG_W-1:SPLIT]);
    ny3lo  = times3(nym[SPLIT-1:0]);
    dneg   = d_r[NW-1];
    w2     = WGW'(d_r) - WGW'(w0_r) - WGW'(w1_r);
    dn     = dneg ? -WGW'(d_r) : WGW'(d_r);
    wn0    = dneg ? -WGW'(w0_r) : WGW'(w0_r);
    wn1    = dneg ? -WGW'(w1_r) : WGW'(w1_r);
    wn2    = dneg ? -w2 : w2;
    ok_w   = !wn0[WGW-1] && !wn1[WGW-1] && !wn2[WGW-1];
    d_zero = (d_r == '0);
  end

  // Per-step operand and accumulate control.
  always_comb begin
    op_a = '0;
    op_b = '0;
    ctl  = '0;
    unique case (step)
      5'd0:  begin op_a = MW'(ent.e0y); op_b = MW'(ent.e1z); ctl.first = 1'b1; end
      5'd1:  begin op_a = MW'(ent.e0z); op_b = MW'(ent.e1y); ctl.sub = 1'b1;
                   ctl.last = 1'b1; ctl.dest = DST_NX; end
      5'd2:  begin op_a = MW'(ent.e0z); op_b = MW'(ent.e1x); ctl.first = 1'b1; end
      5'd3:  begin op_a = MW'(ent.e0x); op_b = MW'(ent.e1z); ctl.sub = 1'b1;
                   ctl.last = 1'b1; ctl.dest = DST_NY; end
      5'd4:  begin op_a = MW'(ent.e0x); op_b = MW'(ent.e1y); ctl.first = 1'b1; end
      5'd5:  begin op_a = MW'(ent.e0y); op_b = MW'(ent.e1x); ctl.sub = 1'b1;
                   ctl.last = 1'b1; ctl.dest = DST_NZ; end
      5'd6:  begin op_a = MW'(ent.bzc); op_b = MW'(ent.axc); ctl.first = 1'b1; end
      5'd7:  begin op_a = MW'(ent.cxb); op_b = MW'(ent.azc);
                   ctl.last = 1'b1; ctl.dest = DST_D; end
      5'd8:  begin op_a = MW'(ent.bzc); op_b = MW'(dx); ctl.first = 1'b1; end
      5'd9:  begin op_a = MW'(ent.cxb); op_b = MW'(dz);
                   ctl.last = 1'b1; ctl.dest = DST_W0; end
      5'd10: begin op_a = MW'(ent.azc); op_b = MW'(dx); ctl.first = 1'b1;
                   ctl.sub = 1'b1; end
      5'd11: begin op_a = MW'(ent.axc); op_b = MW'(dz);
                   ctl.last = 1'b1; ctl.dest = DST_W1; end
      5'd12: begin op_a = MW'(nym[MAG_W-1:SPLIT]); op_b = MW'(ny3hi);
                   ctl.first = 1'b1; ctl.shift = SHIFT_W'(2 * SPLIT); end
      5'd13: begin op_a = MW'(nym[MAG_W-1:SPLIT]); op_b = MW'(ny3lo);
                   ctl.shift = SHIFT_W'(SPLIT + 1); end
      5'd14: begin op_a = MW'(nym[SPLIT-1:0]); op_b = MW'(ny3lo); end
      5'd15: begin op_a = MW'(nxm[MAG_W-1:SPLIT]); op_b = MW'(nxm[MAG_W-1:SPLIT]);
                   ctl.sub = 1'b1; ctl.shift = SHIFT_W'(2 * SPLIT); end
      5'd16: begin op_a = MW'(nxm[MAG_W-1:SPLIT]); op_b = MW'(nxm[SPLIT-1:0]);
                   ctl.sub = 1'b1; ctl.shift = SHIFT_W'(SPLIT + 1); end
      5'd17: begin op_a = MW'(nxm[SPLIT-1:0]); op_b = MW'(nxm[SPLIT-1:0]);
                   ctl.sub = 1'b1; end
      5'd18: begin op_a = MW'(nzm[MAG_W-1:SPLIT]); op_b = MW'(nzm[MAG_W-1:SPLIT]);
                   ctl.sub = 1'b1; ctl.shift = SHIFT_W'(2 * SPLIT); end
      5'd19: begin op_a = MW'(nzm[MAG_W-1:SPLIT]); op_b = MW'(nzm[SPLIT-1:0]);
                   ctl.sub = 1'b1; ctl.shift = SHIFT_W'(SPLIT + 1); end
      5'd20: begin op_a = MW'(nzm[SPLIT-1:0]); op_b = MW'(nzm[SPLIT-1:0]);
                   ctl.sub = 1'b1; ctl.last = 1'b1; ctl.dest = DST_SLOPE; end
      5'd21: begin op_a = MW'(wn0[MAG_W-1:SPLIT]); op_b = MW'(ent.ay);
                   ctl.first = 1'b1; ctl.shift = SHIFT_W'(SPLIT); end
      5'd22: begin op_a = MW'(wn0[SPLIT-1:0]); op_b = MW'(ent.ay); end
      5'd23: begin op_a = MW'(wn1[MAG_W-1:SPLIT]); op_b = MW'(ent.by);
                   ctl.shift = SHIFT_W'(SPLIT); end
      5'd24: begin op_a = MW'(wn1[SPLIT-1:0]); op_b = MW'(ent.by); end
      5'd25: begin op_a = MW'(wn2[MAG_W-1:SPLIT]); op_b = MW'(ent.cy);
                   ctl.shift = SHIFT_W'(SPLIT); end
      5'd26: begin op_a = MW'(wn2[SPLIT-1:0]); op_b = MW'(ent.cy);
                   ctl.last = 1'b1; ctl.dest = DST_SUM; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Accumulate stage, fed by the multiplier register.
  always_comb begin
    shifted  = AW'(prod) <<< pctl.shift;
    base     = pctl.first ? '0 : acc;
    acc_next = pctl.sub ? base - shifted : base + shifted;
  end

  // Divider set-up and final decision.
  always_comb begin
    msum = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
    y    = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    pass = !wall && !d_zero && ok_w && (y >= window_low) && (y <= window_high) &&
           (!have_ground || (y > YW'(best_height)));
  end

  assign slot_free    = !result_valid || result_ready;
  assign pop_ready    = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_entry.is_tri) begin
            state_next = B_MUL;
          end else if (pop_entry.last) begin
            state_next = B_EMIT;
          end
        end
      end
      B_MUL:    if (step == LAST_STEP) state_next = B_DRAIN;
      B_DRAIN:  state_next = B_DIVSET;
      B_DIVSET: state_next = B_DIV;
      B_DIV:    if (dcnt == DIV_LAST) state_next = B_FINISH;
      B_FINISH: state_next = ent.last ? B_EMIT : B_IDLE;
      B_EMIT:   if (slot_free) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // Query state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_x      <= '0;
      point_z      <= '0;
      window_low   <= '0;
      window_high  <= '0;
      best_height  <= '0;
      have_ground  <= 1'b0;
      result_valid <= 1'b0;
      pv           <= 1'b0;
    end else begin
      pv <= (state == B_MUL);
      if (state == B_EMIT && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == B_IDLE && pop_valid && !pop_entry.is_tri) begin
        point_x     <= pop_entry.ax;
        point_z     <= pop_entry.az;
        window_low  <= YW'(pop_entry.ay) - $signed({2'b00, down_reach});
        window_high <= YW'(pop_entry.ay) + $signed({2'b00, up_reach});
        best_height <= '0;
        have_ground <= 1'b0;
      end
      if (state == B_FINISH && pass) begin
        best_height <= y[CW-1:0];
        have_ground <= 1'b1;
      end
      if (state == B_EMIT && slot_free) begin
        result.ground_found  <= have_ground;
        result.ground_height <= have_ground ? best_height : '0;
        best_height          <= '0;
        have_ground          <= 1'b0;
      end
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      ent  <= pop_entry;
      step <= '0;
    end
    if (state == B_MUL) begin
      prod <= op_a * op_b;
      pctl <= ctl;
      step <= step + 1'b1;
    end
    if (pv) begin
      acc <= acc_next;
      if (pctl.last) begin
        unique case (pctl.dest)
          DST_NX:    nx    <= acc_next[NW-1:0];
          DST_NY:    ny    <= acc_next[NW-1:0];
          DST_NZ:    nz    <= acc_next[NW-1:0];
          DST_D:     d_r   <= acc_next[NW-1:0];
          DST_W0:    w0_r  <= acc_next[NW-1:0];
          DST_W1:    w1_r  <= acc_next[NW-1:0];
          DST_SLOPE: wall  <= acc_next[AW-1];
          DST_SUM:   sum_r <= acc_next[SW-1:0];
          default:   ;
        endcase
      end
    end
    if (state == B_DIVSET) begin
      neg_r <= sum_r[SW-1];
      rem   <= RMW'({msum, 1'b0}) + RMW'(dn[WGW-2:0]);
      dsh   <= RMW'({dn[WGW-2:0], 1'b0}) << (QW - 1);
      quo   <= '0;
      dcnt  <= '0;
    end
    if (state == B_DIV) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        quo <= {quo[QW-2:0], 1'b0};
      end
      dsh  <= dsh >> 1;
      dcnt <= dcnt + 1'b1;
    end
  end

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    state == B_DRAIN |-> pv && pctl.last && pctl.dest == DST_SUM)
    else $error("last product not in flight at drain");

  a_seq_end: assert property (@(posedge clk) disable iff (rst)
    state == B_MUL && step == LAST_STEP |=> state == B_DRAIN)
    else $error("sequencer did not end after last step");

  a_best_in_window: assert property (@(posedge clk) disable iff (rst)
    have_ground |-> (YW'(best_height) >= window_low) && (YW'(best_height) <= window_high))
    else $error("kept height outside window");

  a_zero_when_none: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.ground_found |-> result.ground_height == '0)
    else $error("height not zero without ground");

endmodule
